### hdl/dpq_pkg.sv
package dpq_pkg;

  localparam int NORM_DEPTH  = 512;
  localparam int ALARM_DEPTH = 128;
  localparam int NORM_AW     = $clog2(NORM_DEPTH);
  localparam int ALARM_AW    = $clog2(ALARM_DEPTH);
  localparam int IDX_W       = (NORM_AW > ALARM_AW) ? NORM_AW : ALARM_AW;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        kind;
    logic        urgent;
    logic        first;
    logic [15:0] frame_len;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_urgent;
    logic       tx_frame_end;
  } out_t;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_CONT,
    OP_SEND
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        urgent;
    logic [15:0] frame_len;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_BYTE
  } back_state_t;

  function automatic logic [NORM_AW-1:0] norm_next(input logic [NORM_AW-1:0] x);
    return (x == NORM_AW'(NORM_DEPTH - 1)) ? '0 : x + NORM_AW'(1);
  endfunction

  function automatic logic [ALARM_AW-1:0] alarm_next(input logic [ALARM_AW-1:0] x);
    return (x == ALARM_AW'(ALARM_DEPTH - 1)) ? '0 : x + ALARM_AW'(1);
  endfunction

endpackage

### hdl/dpq_ram.sv
module dpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dpq_front.sv
module dpq_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  dpq_pkg::in_t item,
  output logic         busy,
  output logic         cmd_valid,
  output dpq_pkg::cmd_t cmd,
  input  logic         pop
);

  import dpq_pkg::*;

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_idx;
  logic [FIFO_AW-1:0] rd_idx;
  logic [FIFO_AW:0]   count;
  logic               push;
  cmd_t               cls;

  assign busy      = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_idx];

  always_comb begin
    cls.urgent    = item.urgent;
    cls.frame_len = item.frame_len;
    cls.data_byte = item.data_byte;
    if (item.kind) begin
      cls.op = OP_SEND;
    end else if (item.first) begin
      cls.op = OP_FIRST;
    end else begin
      cls.op = OP_CONT;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx + FIFO_AW'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end
  end

endmodule

### hdl/dpq_back.sv
module dpq_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  dpq_pkg::cmd_t cmd,
  output logic          pop,
  output logic          done,
  output dpq_pkg::out_t result
);

  import dpq_pkg::*;

  back_state_t         state, state_next;

  logic [NORM_AW-1:0]  nb_head, nb_head_next, nb_tail, nb_tail_next;
  logic [NORM_AW-1:0]  nf_head, nf_head_next, nf_tail, nf_tail_next;
  logic [ALARM_AW-1:0] ab_head, ab_head_next, ab_tail, ab_tail_next;
  logic [ALARM_AW-1:0] af_head, af_head_next, af_tail, af_tail_next;

  logic                send_active, send_active_next;
  logic                send_urgent, send_urgent_next;
  logic [IDX_W-1:0]    send_left, send_left_next;

  logic [IDX_W-1:0]    wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0]    wr_left, wr_left_next;
  logic [IDX_W-1:0]    wr_len, wr_len_next;
  logic                wr_open, wr_open_next;
  logic                wr_urgent, wr_urgent_next;

  logic                done_next;
  out_t                result_next;

  logic                nbyte_we, abyte_we, nlen_we, alen_we;
  logic [NORM_AW-1:0]  nbyte_waddr;
  logic [ALARM_AW-1:0] abyte_waddr;
  logic [7:0]          byte_wdata;
  logic [NORM_AW-1:0]  nlen_wdata;
  logic [ALARM_AW-1:0] alen_wdata;
  logic [7:0]          nbyte_rdata, abyte_rdata;
  logic [NORM_AW-1:0]  nlen_rdata;
  logic [ALARM_AW-1:0] alen_rdata;

  logic [NORM_AW-1:0]  n_free;
  logic [ALARM_AW-1:0] a_free;
  logic                n_ok, a_ok;

  logic                do_wr;
  logic                wq;
  logic [IDX_W-1:0]    wptr, wlen, wleft, pnext;

  dpq_ram #(.WIDTH(8), .DEPTH(NORM_DEPTH)) u_nbytes (
    .clk(clk), .we(nbyte_we), .waddr(nbyte_waddr), .wdata(byte_wdata),
    .raddr(nb_tail), .rdata(nbyte_rdata)
  );

  dpq_ram #(.WIDTH(8), .DEPTH(ALARM_DEPTH)) u_abytes (
    .clk(clk), .we(abyte_we), .waddr(abyte_waddr), .wdata(byte_wdata),
    .raddr(ab_tail), .rdata(abyte_rdata)
  );

  dpq_ram #(.WIDTH(NORM_AW), .DEPTH(NORM_DEPTH)) u_nlens (
    .clk(clk), .we(nlen_we), .waddr(nf_head), .wdata(nlen_wdata),
    .raddr(nf_tail), .rdata(nlen_rdata)
  );

  dpq_ram #(.WIDTH(ALARM_AW), .DEPTH(ALARM_DEPTH)) u_alens (
    .clk(clk), .we(alen_we), .waddr(af_head), .wdata(alen_wdata),
    .raddr(af_tail), .rdata(alen_rdata)
  );

  always_comb begin
    n_free = (nb_head >= nb_tail) ? NORM_AW'(NORM_DEPTH - 1) - (nb_head - nb_tail)
                                  : nb_tail - nb_head - NORM_AW'(1);
    a_free = (ab_head >= ab_tail) ? ALARM_AW'(ALARM_DEPTH - 1) - (ab_head - ab_tail)
                                  : ab_tail - ab_head - ALARM_AW'(1);
    n_ok = (cmd.frame_len != '0) && ({1'b0, cmd.frame_len} < 17'(NORM_DEPTH)) &&
           (cmd.frame_len <= 16'(n_free)) && (norm_next(nf_head) != nf_tail);
    a_ok = (cmd.frame_len != '0) && ({1'b0, cmd.frame_len} < 17'(ALARM_DEPTH)) &&
           (cmd.frame_len <= 16'(a_free)) && (alarm_next(af_head) != af_tail);
  end

  always_comb begin
    state_next       = state;
    nb_head_next     = nb_head;
    nb_tail_next     = nb_tail;
    nf_head_next     = nf_head;
    nf_tail_next     = nf_tail;
    ab_head_next     = ab_head;
    ab_tail_next     = ab_tail;
    af_head_next     = af_head;
    af_tail_next     = af_tail;
    send_active_next = send_active;
    send_urgent_next = send_urgent;
    send_left_next   = send_left;
    wr_ptr_next      = wr_ptr;
    wr_left_next     = wr_left;
    wr_len_next      = wr_len;
    wr_open_next     = wr_open;
    wr_urgent_next   = wr_urgent;
    done_next        = 1'b0;
    result_next      = '0;
    pop              = 1'b0;
    do_wr            = 1'b0;
    wq               = wr_urgent;
    wptr             = wr_ptr;
    wlen             = wr_len;
    wleft            = wr_left;
    nbyte_we         = 1'b0;
    abyte_we         = 1'b0;
    nlen_we          = 1'b0;
    alen_we          = 1'b0;
    nbyte_waddr      = wptr[NORM_AW-1:0];
    abyte_waddr      = wptr[ALARM_AW-1:0];
    byte_wdata       = cmd.data_byte;
    nlen_wdata       = wlen[NORM_AW-1:0];
    alen_wdata       = wlen[ALARM_AW-1:0];
    pnext            = '0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.op)
            OP_FIRST: begin
              done_next    = 1'b1;
              wr_open_next = 1'b0;
              if (cmd.urgent ? a_ok : n_ok) begin
                do_wr                = 1'b1;
                wq                   = cmd.urgent;
                wptr                 = cmd.urgent ? IDX_W'(ab_head) : IDX_W'(nb_head);
                wlen                 = cmd.frame_len[IDX_W-1:0];
                wleft                = cmd.frame_len[IDX_W-1:0];
                result_next.accepted = 1'b1;
              end
            end
            OP_CONT: begin
              done_next = 1'b1;
              do_wr     = wr_open;
            end
            OP_SEND: begin
              if (send_active) begin
                state_next = ST_BYTE;
              end else if (af_head != af_tail) begin
                send_urgent_next = 1'b1;
                state_next       = ST_LEN;
              end else if (nf_head != nf_tail) begin
                send_urgent_next = 1'b0;
                state_next       = ST_LEN;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_LEN: begin
        send_active_next = 1'b1;
        send_left_next   = send_urgent ? IDX_W'(alen_rdata) : IDX_W'(nlen_rdata);
        state_next       = ST_BYTE;
      end
      ST_BYTE: begin
        done_next             = 1'b1;
        result_next.tx_valid  = 1'b1;
        result_next.tx_byte   = send_urgent ? abyte_rdata : nbyte_rdata;
        result_next.tx_urgent = send_urgent;
        send_left_next        = send_left - IDX_W'(1);
        if (send_urgent) begin
          ab_tail_next = alarm_next(ab_tail);
        end else begin
          nb_tail_next = norm_next(nb_tail);
        end
        if (send_left == IDX_W'(1)) begin
          result_next.tx_frame_end = 1'b1;
          send_active_next         = 1'b0;
          send_urgent_next         = 1'b0;
          if (send_urgent) begin
            af_tail_next = alarm_next(af_tail);
          end else begin
            nf_tail_next = norm_next(nf_tail);
          end
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    nbyte_waddr = wptr[NORM_AW-1:0];
    abyte_waddr = wptr[ALARM_AW-1:0];
    nlen_wdata  = wlen[NORM_AW-1:0];
    alen_wdata  = wlen[ALARM_AW-1:0];

    if (do_wr) begin
      if (wq) begin
        abyte_we = 1'b1;
        pnext    = IDX_W'(alarm_next(wptr[ALARM_AW-1:0]));
      end else begin
        nbyte_we = 1'b1;
        pnext    = IDX_W'(norm_next(wptr[NORM_AW-1:0]));
      end
      if (wleft == IDX_W'(1)) begin
        wr_open_next = 1'b0;
        if (wq) begin
          alen_we      = 1'b1;
          ab_head_next = pnext[ALARM_AW-1:0];
          af_head_next = alarm_next(af_head);
        end else begin
          nlen_we      = 1'b1;
          nb_head_next = pnext[NORM_AW-1:0];
          nf_head_next = norm_next(nf_head);
        end
      end else begin
        wr_open_next   = 1'b1;
        wr_ptr_next    = pnext;
        wr_left_next   = wleft - IDX_W'(1);
        wr_len_next    = wlen;
        wr_urgent_next = wq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      nb_head     <= '0;
      nb_tail     <= '0;
      nf_head     <= '0;
      nf_tail     <= '0;
      ab_head     <= '0;
      ab_tail     <= '0;
      af_head     <= '0;
      af_tail     <= '0;
      send_active <= 1'b0;
      send_urgent <= 1'b0;
      send_left   <= '0;
      wr_ptr      <= '0;
      wr_left     <= '0;
      wr_len      <= '0;
      wr_open     <= 1'b0;
      wr_urgent   <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      nb_head     <= nb_head_next;
      nb_tail     <= nb_tail_next;
      nf_head     <= nf_head_next;
      nf_tail     <= nf_tail_next;
      ab_head     <= ab_head_next;
      ab_tail     <= ab_tail_next;
      af_head     <= af_head_next;
      af_tail     <= af_tail_next;
      send_active <= send_active_next;
      send_urgent <= send_urgent_next;
      send_left   <= send_left_next;
      wr_ptr      <= wr_ptr_next;
      wr_left     <= wr_left_next;
      wr_len      <= wr_len_next;
      wr_open     <= wr_open_next;
      wr_urgent   <= wr_urgent_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### hdl/dual_priority_frame_tx_queue_core.sv
// Two-priority framed transmit queue. Each beat on item is taken when start is high and
// busy is low, and gives exactly one beat on result, marked by done for one cycle; the
// receiver cannot stall, so sample result whenever done is high. A write beat ends in
// the idle state; a uart-ready beat ends there when no frame is pending, else it goes
// through the byte state, after the length state when it opens a new frame, since the
// length and byte memories are read through registers. A two-entry command queue sits
// between the front and the back end, so busy rises only while it is full. Frames are
// chosen alarm first at frame boundaries only, and become sendable on their last byte.
module dual_priority_frame_tx_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dpq_pkg::in_t  item,
  output logic          busy,
  output logic          done,
  output dpq_pkg::out_t result
);

  import dpq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  dpq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  dpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule

### hdl/dpq_checker.sv
module dpq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input dpq_pkg::out_t result
);

  import dpq_pkg::*;

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(start && !busy) - 3'(done);
    end
  end

  a_no_orphan_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> (pending != '0))
    else $error("result beat without an outstanding item");

  a_tx_excludes_accept: assert property (@(posedge clk) disable iff (rst)
    (done && result.tx_valid) |-> !result.accepted)
    else $error("send beat reports frame accept");

  a_idle_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.tx_valid) |->
      (result.tx_byte == '0 && !result.tx_urgent && !result.tx_frame_end))
    else $error("tx fields set without tx_valid");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

endmodule

bind dual_priority_frame_tx_queue_core dpq_checker u_dpq_checker (.*);
